// File: rtl/ufmq_pkg.sv
// ----------------------------------------------------------------------------
// ufmq_pkg
// Shared types and codes for the per-class bounded deque bank.
// ----------------------------------------------------------------------------
package ufmq_pkg;

    // field widths fixed by the interface
    localparam int unsigned CMD_W   = 1;
    localparam int unsigned SEL_W   = 5;
    localparam int unsigned ID_W    = 16;
    localparam int unsigned CAP_W   = 4;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned ENTRY_W = ID_W + 1;

    // selector widened so any queue count up to 64 compares cleanly
    localparam int unsigned SEL_EXT_W = 7;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TAKE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_ADDED    = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_SERVED   = 2'd2,
        STATUS_EMPTY    = 2'd3
    } ufmq_status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_META  = 2'd1,
        ST_ENTRY = 2'd2,
        ST_OUT   = 2'd3
    } ufmq_state_t;

endpackage

// File: rtl/urgent_front_multi_queue_top.sv
// Sequence: an accepted word goes through META, then OUT for add, reject and empty,
//   and through META, ENTRY, then OUT for a served take (ENTRY for the entry memory read).
// Flow: a new word is taken only in IDLE, after the serial read-modify-write of the
//   per-queue head/count memory, the entry memory access and the output load of the last.
// Reset: head/count valid bits clear (all queues empty), capacity returns to 5,
//   entry memory is not cleared; the block takes words right after reset.
// ----------------------------------------------------------------------------
// urgent_front_multi_queue_top
// Bank of bounded deques, one per class. Regular adds go to the tail, urgent
// adds to the head, takes pop the head. Head/count and entries live in
// synchronous memories; one word is processed at a time.
// ----------------------------------------------------------------------------
module urgent_front_multi_queue_top #(
    parameter int unsigned NUM_QUEUES  = 32,
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,

    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [4:0]  queue_sel,
    input  logic [15:0] patient_id,
    input  logic        urgent,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] served_id,
    output logic        served_urgent,
    output logic [3:0]  queue_count
);

    // derived widths
    localparam int unsigned QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int unsigned HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MW  = HW + CW;
    localparam int unsigned NE  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int unsigned AW  = (NE > 1) ? $clog2(NE) : 1;
    localparam int unsigned KW  = (CW > ufmq_pkg::CAP_W) ? CW : ufmq_pkg::CAP_W;
    localparam int unsigned EXW = ufmq_pkg::SEL_EXT_W;

    // state and configuration
    ufmq_pkg::ufmq_state_t state_reg, state_next;
    logic [ufmq_pkg::CAP_W-1:0] cap_reg;

    // latched command word
    logic                     op_cmd_reg;
    logic [ufmq_pkg::SEL_W-1:0] op_sel_reg;
    logic [ufmq_pkg::ID_W-1:0]  op_id_reg;
    logic                     op_urg_reg;

    // memories
    logic [MW-1:0]                 meta_mem  [NUM_QUEUES];
    logic [ufmq_pkg::ENTRY_W-1:0]  entry_mem [NE];
    logic [NUM_QUEUES-1:0]         meta_vld_reg;
    logic [MW-1:0]                 meta_rd_reg;
    logic                          meta_rd_vld_reg;
    logic [ufmq_pkg::ENTRY_W-1:0]  entry_rd_reg;

    // result staging and output register
    ufmq_pkg::ufmq_status_t        res_status_reg;
    logic [ufmq_pkg::COUNT_W-1:0]  res_count_reg;
    ufmq_pkg::ufmq_status_t        out_status_reg;
    logic [ufmq_pkg::ID_W-1:0]     out_id_reg;
    logic                          out_urg_reg;
    logic [ufmq_pkg::COUNT_W-1:0]  out_count_reg;
    logic                          out_valid_reg;

    // handshake
    logic in_accept;
    logic out_load;

    // selector decode
    logic [EXW-1:0] in_sel_ext;
    logic [QW-1:0]  in_qidx;
    logic [EXW-1:0] op_sel_ext;
    logic [QW-1:0]  op_qidx;
    logic           in_range;

    // per-queue update
    logic [HW-1:0]  head_cur;
    logic [CW-1:0]  cnt_cur;
    logic [KW-1:0]  cap_eff;
    logic [KW-1:0]  cnt_ext;
    logic           add_ok;
    logic           take_ok;
    logic [HW-1:0]  head_dec;
    logic [HW-1:0]  head_inc;
    logic [HW:0]    tail_sum;
    logic [HW-1:0]  tail_slot;
    logic [HW-1:0]  head_new;
    logic [CW-1:0]  cnt_new;
    logic [HW-1:0]  ent_slot;
    logic [AW-1:0]  ent_addr;
    ufmq_pkg::ufmq_status_t meta_status;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ufmq_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == ufmq_pkg::ST_IDLE);
    assign out_load  = (state_reg == ufmq_pkg::ST_OUT) && (!out_valid_reg || !out_stall);

    // selector to queue index
    assign in_sel_ext = EXW'(queue_sel);
    assign in_qidx    = in_sel_ext[QW-1:0];
    assign op_sel_ext = EXW'(op_sel_reg);
    assign op_qidx    = op_sel_ext[QW-1:0];
    assign in_range   = (op_sel_ext < EXW'(NUM_QUEUES));

    // head and count of the addressed queue, empty until first written
    assign head_cur = meta_rd_vld_reg ? meta_rd_reg[MW-1:CW] : '0;
    assign cnt_cur  = meta_rd_vld_reg ? meta_rd_reg[CW-1:0]  : '0;

    // capacity saturates at the ring depth
    assign cap_eff = (KW'(cap_reg) > KW'(QUEUE_DEPTH)) ? KW'(QUEUE_DEPTH) : KW'(cap_reg);
    assign cnt_ext = KW'(cnt_cur);

    assign add_ok  = in_range && (op_cmd_reg == ufmq_pkg::CMD_ADD) && (cnt_ext < cap_eff);
    assign take_ok = in_range && (op_cmd_reg == ufmq_pkg::CMD_TAKE) && (cnt_cur != '0);

    // ring pointer arithmetic
    assign head_dec  = (head_cur == '0) ? HW'(QUEUE_DEPTH - 1) : head_cur - HW'(1);
    assign head_inc  = (head_cur == HW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + HW'(1);
    assign tail_sum  = (HW+1)'(head_cur) + (HW+1)'(cnt_cur);
    assign tail_slot = (tail_sum >= (HW+1)'(QUEUE_DEPTH))
                     ? HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);

    // next head/count and entry slot
    always_comb
    begin
        head_new = head_cur;
        cnt_new  = cnt_cur;
        ent_slot = head_cur;
        if (add_ok)
        begin
            head_new = op_urg_reg ? head_dec : head_cur;
            cnt_new  = cnt_cur + CW'(1);
            ent_slot = op_urg_reg ? head_dec : tail_slot;
        end
        else if (take_ok)
        begin
            head_new = head_inc;
            cnt_new  = cnt_cur - CW'(1);
        end
    end

    assign ent_addr = AW'(int'(op_qidx) * QUEUE_DEPTH + int'(ent_slot));

    // status of the current word
    always_comb
    begin
        priority if (add_ok)
            meta_status = ufmq_pkg::STATUS_ADDED;
        else if (take_ok)
            meta_status = ufmq_pkg::STATUS_SERVED;
        else if (op_cmd_reg == ufmq_pkg::CMD_ADD)
            meta_status = ufmq_pkg::STATUS_REJECTED;
        else
            meta_status = ufmq_pkg::STATUS_EMPTY;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ufmq_pkg::ST_IDLE:
                if (in_accept)
                    state_next = ufmq_pkg::ST_META;
            ufmq_pkg::ST_META:
                state_next = take_ok ? ufmq_pkg::ST_ENTRY : ufmq_pkg::ST_OUT;
            ufmq_pkg::ST_ENTRY:
                state_next = ufmq_pkg::ST_OUT;
            ufmq_pkg::ST_OUT:
                if (out_load)
                    state_next = ufmq_pkg::ST_IDLE;
            default:
                state_next = ufmq_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ufmq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= ufmq_pkg::CAP_RESET;
        else if (cfg_valid && cfg_ready)
            cap_reg <= cfg_data;
    end

    // latch command word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_cmd_reg <= cmd;
            op_sel_reg <= queue_sel;
            op_id_reg  <= patient_id;
            op_urg_reg <= urgent;
        end
    end

    // head/count memory: read on accept, write back after update
    always_ff @(posedge clk)
    begin
        if (in_accept)
            meta_rd_reg <= meta_mem[in_qidx];
        if ((state_reg == ufmq_pkg::ST_META) && (add_ok || take_ok))
            meta_mem[op_qidx] <= {head_new, cnt_new};
    end

    // per-queue valid bits stand in for the all-zero reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_vld_reg    <= '0;
            meta_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                meta_rd_vld_reg <= meta_vld_reg[in_qidx];
            if ((state_reg == ufmq_pkg::ST_META) && (add_ok || take_ok))
                meta_vld_reg[op_qidx] <= 1'b1;
        end
    end

    // entry memory: single port, write on add, read on take
    always_ff @(posedge clk)
    begin
        if (state_reg == ufmq_pkg::ST_META)
        begin
            if (add_ok)
                entry_mem[ent_addr] <= {op_urg_reg, op_id_reg};
            else if (take_ok)
                entry_rd_reg <= entry_mem[ent_addr];
        end
    end

    // result staging
    always_ff @(posedge clk)
    begin
        if (state_reg == ufmq_pkg::ST_META)
        begin
            res_status_reg <= meta_status;
            res_count_reg  <= in_range ? ufmq_pkg::COUNT_W'(cnt_new) : '0;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_count_reg  <= res_count_reg;
            if (res_status_reg == ufmq_pkg::STATUS_SERVED)
            begin
                out_id_reg  <= entry_rd_reg[ufmq_pkg::ID_W-1:0];
                out_urg_reg <= entry_rd_reg[ufmq_pkg::ID_W];
            end
            else
            begin
                out_id_reg  <= '0;
                out_urg_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign served_id     = out_id_reg;
    assign served_urgent = out_urg_reg;
    assign queue_count   = out_count_reg;

    // an accepted word always goes to the head/count lookup
    a_accept_to_meta: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ufmq_pkg::ST_META))
        else $error("accepted word did not start a lookup");

    // an entry read only follows a non-empty queue
    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ufmq_pkg::ST_ENTRY) |-> ($past(cnt_cur) != '0))
        else $error("entry read issued on an empty queue");

    // a stored count never passes the ring depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ufmq_pkg::ST_META) |-> (KW'(cnt_cur) <= KW'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    // an add never pushes the count over capacity
    a_add_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ufmq_pkg::ST_META) && add_ok) |-> (KW'(cnt_new) <= cap_eff))
        else $error("add exceeded capacity");

    // id field is zero unless the word reports a served entry
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ufmq_pkg::STATUS_SERVED))
            |-> ((out_id_reg == '0) && !out_urg_reg))
        else $error("served fields set without a served status");

endmodule

// File: tb/tb_urgent_front_multi_queue_top.sv
// ----------------------------------------------------------------------------
// tb_urgent_front_multi_queue_top
// Self-checking bench for the per-class bounded deque bank. A directed table
// covers empty takes, the full reject, urgent and regular order, the outer
// queues, a zero capacity and a capacity that drops below a count. Random
// phases follow, each under a newly written capacity and add/take mix, mostly
// on a few hot queues so they fill and drain. Every result word is compared
// with a behavioral predictor of the deques, with random gaps on the command
// side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_urgent_front_multi_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_QUEUES      = 32;
    localparam int QUEUE_DEPTH     = 8;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 195;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int MAX_REPORTS     = 10;
    localparam int DIRECTED_ROWS   = 22;

    // kinds of directed rows and how their result is known
    localparam logic ROW_WORD  = 1'b0;
    localparam logic ROW_CFG   = 1'b1;
    localparam logic PREDICTED = 1'b0;
    localparam logic TYPED     = 1'b1;

    typedef struct packed {
        ufmq_pkg::ufmq_status_t status;
        logic [15:0]  served_id;
        logic         served_urgent;
        logic [3:0]   queue_count;
    } deque_result_t;

    typedef struct packed {
        logic         kind;
        logic [3:0]   cap_value;
        logic         op;
        logic [4:0]   sel;
        logic [15:0]  pid;
        logic         urg;
        logic         known;
        ufmq_pkg::ufmq_status_t status;
        logic [15:0]  served_id;
        logic         served_urgent;
        logic [3:0]   queue_count;
    } probe_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [4:0]  queue_sel;
    logic [15:0] patient_id;
    logic        urgent;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] served_id;
    logic        served_urgent;
    logic [3:0]  queue_count;

    // predicted deque contents
    logic [ufmq_pkg::ENTRY_W-1:0] slot_mem [NUM_QUEUES][QUEUE_DEPTH];
    logic [2:0]         head_ptr [NUM_QUEUES];
    logic [3:0]         fill     [NUM_QUEUES];
    logic [3:0]         capacity_reg;

    deque_result_t pending_results [$];

    int failures     = 0;
    int words_sent   = 0;
    int cap_writes   = 0;
    int cycle_count  = 0;
    int in_gap_max   = 9;
    int out_gap_max  = 9;
    int out_wait     = 0;
    int seen_status [4];

    // directed words: reset capacity is 5 until the first write
    probe_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_TAKE, 5'd0,  16'h0000, 1'b0, TYPED,
          ufmq_pkg::STATUS_EMPTY, 16'h0000, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd0,  16'h0000, 1'b0, TYPED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd1},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd0,  16'hFFFF, 1'b1, TYPED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd2},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd0,  16'h1234, 1'b0, PREDICTED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd0,  16'hABCD, 1'b1, PREDICTED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd0,  16'h5555, 1'b0, TYPED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd5},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd0,  16'hAAAA, 1'b1, TYPED,
          ufmq_pkg::STATUS_REJECTED, 16'h0000, 1'b0, 4'd5},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_TAKE, 5'd0,  16'h0000, 1'b0, TYPED,
          ufmq_pkg::STATUS_SERVED, 16'hABCD, 1'b1, 4'd4},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_TAKE, 5'd0,  16'hFFFF, 1'b1, PREDICTED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_TAKE, 5'd0,  16'h0000, 1'b0, PREDICTED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_TAKE, 5'd0,  16'h7777, 1'b1, PREDICTED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_TAKE, 5'd0,  16'h0000, 1'b0, TYPED,
          ufmq_pkg::STATUS_SERVED, 16'h5555, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_TAKE, 5'd0,  16'h0000, 1'b0, TYPED,
          ufmq_pkg::STATUS_EMPTY, 16'h0000, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd31, 16'hFFFF, 1'b1, TYPED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd1},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_TAKE, 5'd31, 16'hFFFF, 1'b1, TYPED,
          ufmq_pkg::STATUS_SERVED, 16'hFFFF, 1'b1, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd16, 16'h8000, 1'b0, PREDICTED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd15, 16'h7FFF, 1'b1, PREDICTED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd16, 16'h7FFF, 1'b1, PREDICTED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0},
        '{ROW_CFG,  4'd0, ufmq_pkg::CMD_ADD,  5'd0,  16'h0000, 1'b0, PREDICTED,
          ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_ADD,  5'd16, 16'h0001, 1'b0, TYPED,
          ufmq_pkg::STATUS_REJECTED, 16'h0000, 1'b0, 4'd2},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_TAKE, 5'd16, 16'h0000, 1'b0, TYPED,
          ufmq_pkg::STATUS_SERVED, 16'h7FFF, 1'b1, 4'd1},
        '{ROW_WORD, 4'd0, ufmq_pkg::CMD_TAKE, 5'd15, 16'h0000, 1'b0, TYPED,
          ufmq_pkg::STATUS_SERVED, 16'h7FFF, 1'b1, 4'd0}
    };

    // capacity (the last phase draws its own) and add share for each random phase
    int cap_plan [PHASES] = '{8, 1, 15, 0, 3, 8, 2, 15, 1, 5};
    int add_plan [PHASES] = '{75, 30, 80, 60, 50, 75, 40, 85, 25, 55};

    urgent_front_multi_queue_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .queue_sel     (queue_sel),
        .patient_id    (patient_id),
        .urgent        (urgent),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .served_id     (served_id),
        .served_urgent (served_urgent),
        .queue_count   (queue_count)
    );

    always #5 clk = ~clk;

    // one command word applied to the predicted deques
    function automatic deque_result_t apply_word(input logic op, input logic [4:0] q,
                                                 input logic [15:0] pid, input logic urg);
        deque_result_t r;
        logic [3:0]    limit;
        logic [2:0]    slot;
        r = '{ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0};
        // capacity above the depth saturates
        limit = (capacity_reg > 4'(QUEUE_DEPTH)) ? 4'(QUEUE_DEPTH) : capacity_reg;
        if (op == ufmq_pkg::CMD_ADD)
        begin
            if (fill[q] >= limit)
            begin
                r.status = ufmq_pkg::STATUS_REJECTED;
            end
            else
            begin
                // urgent goes in front of the head, regular after the tail
                if (urg)
                begin
                    head_ptr[q] = head_ptr[q] - 3'd1;
                    slot        = head_ptr[q];
                end
                else
                begin
                    slot = head_ptr[q] + fill[q][2:0];
                end
                slot_mem[q][slot] = {urg, pid};
                fill[q]           = fill[q] + 4'd1;
            end
        end
        else if (fill[q] == 4'd0)
        begin
            r.status = ufmq_pkg::STATUS_EMPTY;
        end
        else
        begin
            r.status                         = ufmq_pkg::STATUS_SERVED;
            {r.served_urgent, r.served_id}   = slot_mem[q][head_ptr[q]];
            head_ptr[q]                      = head_ptr[q] + 3'd1;
            fill[q]                          = fill[q] - 4'd1;
        end
        r.queue_count = fill[q];
        return r;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // drive one command word, called and returning at a falling edge
    task automatic send_word(input logic op, input logic [4:0] q, input logic [15:0] pid,
                             input logic urg, input logic known,
                             input deque_result_t typed_result);
        int            gap;
        deque_result_t predicted;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        queue_sel  <= q;
        patient_id <= pid;
        urgent     <= urg;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predicted = apply_word(op, q, pid, urg);
        pending_results.push_back(known ? typed_result : predicted);
        words_sent++;
        @(negedge clk);
    endtask

    // capacity write once every pending word has come back
    task automatic write_capacity(input logic [3:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        capacity_reg = value;
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [4:0] hot [4];
        logic [4:0] q;
        logic       op;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 4'd0;
        in_valid     = 1'b0;
        cmd          = ufmq_pkg::CMD_ADD;
        queue_sel    = 5'd0;
        patient_id   = 16'h0000;
        urgent       = 1'b0;
        capacity_reg = ufmq_pkg::CAP_RESET;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            head_ptr[i] = 3'd0;
            fill[i]     = 4'd0;
        end
        for (int i = 0; i < 4; i++) seen_status[i] = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                write_capacity(directed_rows[i].cap_value);
            end
            else
            begin
                send_word(directed_rows[i].op, directed_rows[i].sel, directed_rows[i].pid,
                          directed_rows[i].urg, directed_rows[i].known,
                          '{directed_rows[i].status, directed_rows[i].served_id,
                            directed_rows[i].served_urgent, directed_rows[i].queue_count});
            end
        end

        // random phases, mostly on a few hot queues so they fill and drain
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
            begin
                write_capacity(4'($urandom_range(0, 15)));
            end
            else
            begin
                write_capacity(4'(cap_plan[ph]));
            end
            in_gap_max  = (ph % 4 == 1) ? 0 : 9;
            out_gap_max = (ph % 4 == 1 || ph % 4 == 3) ? 0 : 9;
            foreach (hot[i]) hot[i] = 5'($urandom_range(0, NUM_QUEUES - 1));
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                q  = ($urandom_range(0, 9) < 8) ? hot[$urandom_range(0, 3)]
                                                : 5'($urandom_range(0, NUM_QUEUES - 1));
                op = ($urandom_range(0, 99) < add_plan[ph]) ? ufmq_pkg::CMD_ADD
                                                            : ufmq_pkg::CMD_TAKE;
                send_word(op, q, 16'($urandom), 1'($urandom), PREDICTED,
                          '{ufmq_pkg::STATUS_ADDED, 16'h0000, 1'b0, 4'd0});
            end
        end

        // let everything drain
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d command words under %0d capacity writes", words_sent, cap_writes);
        $display("results: %0d added, %0d rejected, %0d served, %0d empty, %0d failures",
                 seen_status[ufmq_pkg::STATUS_ADDED], seen_status[ufmq_pkg::STATUS_REJECTED],
                 seen_status[ufmq_pkg::STATUS_SERVED], seen_status[ufmq_pkg::STATUS_EMPTY],
                 failures);
        if (failures == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // result check and next stall draw on every accepted word
    always @(posedge clk)
    begin
        deque_result_t got;
        deque_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{ufmq_pkg::ufmq_status_t'(status), served_id, served_urgent, queue_count};
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("result word with nothing pending: status %0d id %h",
                                       got.status, got.served_id));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.served_id !== want.served_id ||
                    got.served_urgent !== want.served_urgent ||
                    got.queue_count !== want.queue_count)
                begin
                    note_failure($sformatf(
                        "expected status %0d id %h urg %b count %0d, got %0d %h %b %0d",
                        want.status, want.served_id, want.served_urgent, want.queue_count,
                        got.status, got.served_id, got.served_urgent, got.queue_count));
                end
            end
            seen_status[got.status]++;
            out_wait = $urandom_range(0, out_gap_max);
        end
    end

    // result side stall
    always @(negedge clk)
    begin
        if (out_wait > 0)
        begin
            out_stall <= 1'b1;
            out_wait  = out_wait - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/ufmq_pkg.sv
rtl/urgent_front_multi_queue_top.sv
tb/tb_urgent_front_multi_queue_top.sv
